>>> rtl/core/axis_angle_rotation_matrix_macros.svh
// assertion helpers for the rotation matrix block
`ifndef AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH

// same-cycle implication
`define AARM_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define AARM_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/aarm_pkg.sv
package aarm_pkg;

	localparam int FRAC_BITS     = 14;
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_LEN      = 24;
	localparam int CSTG          = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
	localparam int IW            = $clog2(ATAN_LEN);
	localparam int CORD_FRAC     = 30;
	localparam int OUT_FRAC      = 14;
	localparam int ANG_SH        = CORD_FRAC - 13;
	localparam int CW            = 34;
	localparam int ZW            = 36;
	localparam int TW            = FRAC_BITS + 2;
	localparam int RS            = CORD_FRAC - FRAC_BITS;
	localparam int LEN_W         = 32;
	localparam int N_W           = 48;
	localparam int ROOT_W        = 24;
	localparam int RW            = ROOT_W + 3;
	localparam int SQ_STEPS      = ROOT_W;
	localparam int QB            = FRAC_BITS + 2;
	localparam int DW            = ROOT_W + QB + 1;
	localparam int NSH           = FRAC_BITS + 8;
	localparam int PW            = 2 * FRAC_BITS + 8;
	localparam int FS            = 2 * FRAC_BITS - OUT_FRAC;

	localparam logic signed [CW-1:0] CORD_GAIN = CW'(652032874);
	localparam logic signed [ZW-1:0] PI_Q30    = ZW'(64'd3373259426);
	localparam logic signed [ZW-1:0] HPI_Q30   = ZW'(64'd1686629713);

	typedef struct packed {
		logic [15:0]      mag_x;
		logic [15:0]      mag_y;
		logic [15:0]      mag_z;
		logic             sgn_x;
		logic             sgn_y;
		logic             sgn_z;
		logic             zero;
		logic [LEN_W-1:0] len2;
	} axis_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 flip;
	} cord_t;

	typedef struct packed {
		logic signed [TW-1:0] c;
		logic signed [TW-1:0] s;
	} trig_t;

	typedef struct packed {
		logic [RW-1:0]     rem;
		logic [ROOT_W-1:0] root;
		logic [N_W-1:0]    n;
	} sqrt_t;

	typedef struct packed {
		logic [15:0] mag_x;
		logic [15:0] mag_y;
		logic [15:0] mag_z;
		logic        sgn_x;
		logic        sgn_y;
		logic        sgn_z;
		logic        zero;
		trig_t       trig;
	} sq_side_t;

	typedef struct packed {
		logic [DW-1:0]     rem_x;
		logic [DW-1:0]     rem_y;
		logic [DW-1:0]     rem_z;
		logic [QB-1:0]     q_x;
		logic [QB-1:0]     q_y;
		logic [QB-1:0]     q_z;
		logic [ROOT_W-1:0] root;
	} div_t;

	typedef struct packed {
		logic  sgn_x;
		logic  sgn_y;
		logic  sgn_z;
		logic  zero;
		trig_t trig;
	} dv_side_t;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic          b;
	} dstep_t;

	typedef struct packed {
		logic signed [15:0] r00;
		logic signed [15:0] r01;
		logic signed [15:0] r02;
		logic signed [15:0] r10;
		logic signed [15:0] r11;
		logic signed [15:0] r12;
		logic signed [15:0] r20;
		logic signed [15:0] r21;
		logic signed [15:0] r22;
	} mat_t;

	function automatic logic signed [ZW-1:0] atan_q30(input logic [IW-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd843314856;
			5'd1:  v = 32'd497837829;
			5'd2:  v = 32'd263043836;
			5'd3:  v = 32'd133525158;
			5'd4:  v = 32'd67021686;
			5'd5:  v = 32'd33543515;
			5'd6:  v = 32'd16775850;
			5'd7:  v = 32'd8388437;
			5'd8:  v = 32'd4194282;
			5'd9:  v = 32'd2097149;
			5'd10: v = 32'd1048575;
			5'd11: v = 32'd524287;
			5'd12: v = 32'd262143;
			5'd13: v = 32'd131071;
			5'd14: v = 32'd65535;
			5'd15: v = 32'd32767;
			5'd16: v = 32'd16383;
			5'd17: v = 32'd8191;
			5'd18: v = 32'd4095;
			5'd19: v = 32'd2047;
			5'd20: v = 32'd1023;
			5'd21: v = 32'd511;
			5'd22: v = 32'd255;
			5'd23: v = 32'd127;
			default: v = 32'd0;
		endcase
		return ZW'(v);
	endfunction

	function automatic dstep_t div_step(input logic [DW-1:0] rem,
			input logic [ROOT_W-1:0] root);
		logic [DW-1:0] d;
		dstep_t        r;
		d = DW'(root) << (QB - 1);
		if (rem >= d) begin
			r.rem = (rem - d) << 1;
			r.b   = 1'b1;
		end else begin
			r.rem = rem << 1;
			r.b   = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/aarm_in_if.sv
interface aarm_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] axis_x;
	logic signed [15:0] axis_y;
	logic signed [15:0] axis_z;
	logic signed [15:0] angle_rad;

	modport source(output valid, axis_x, axis_y, axis_z, angle_rad, input ready);
	modport sink(input valid, axis_x, axis_y, axis_z, angle_rad, output ready);
endinterface

>>> rtl/core/aarm_out_if.sv
interface aarm_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] r00;
	logic signed [15:0] r01;
	logic signed [15:0] r02;
	logic signed [15:0] r10;
	logic signed [15:0] r11;
	logic signed [15:0] r12;
	logic signed [15:0] r20;
	logic signed [15:0] r21;
	logic signed [15:0] r22;

	modport source(output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		input ready);
	modport sink(input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		output ready);
endinterface

>>> rtl/core/aarm_cordic_cell.sv
module aarm_cordic_cell import aarm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [IW-1:0] idx,
	input  logic          in_valid,
	input  cord_t         in_cord,
	input  axis_t         in_axis,
	output logic          out_valid,
	output cord_t         out_cord,
	output axis_t         out_axis
);

	logic                 valid_q;
	cord_t                cord_q;
	axis_t                axis_q;
	cord_t                nxt;
	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	logic signed [ZW-1:0] at;

	always_comb begin
		dx  = in_cord.y >>> idx;
		dy  = in_cord.x >>> idx;
		at  = atan_q30(idx);
		nxt = in_cord;
		if (!in_cord.z[ZW-1]) begin
			nxt.x = in_cord.x - dx;
			nxt.y = in_cord.y + dy;
			nxt.z = in_cord.z - at;
		end else begin
			nxt.x = in_cord.x + dx;
			nxt.y = in_cord.y - dy;
			nxt.z = in_cord.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cord_q <= nxt;
			axis_q <= in_axis;
		end
	end

	assign out_valid = valid_q;
	assign out_cord  = cord_q;
	assign out_axis  = axis_q;

endmodule

>>> rtl/core/aarm_sqrt_cell.sv
module aarm_sqrt_cell import aarm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  sqrt_t    in_sq,
	input  sq_side_t in_side,
	output logic     out_valid,
	output sqrt_t    out_sq,
	output sq_side_t out_side
);

	logic          valid_q;
	sqrt_t         sq_q;
	sq_side_t      side_q;
	sqrt_t         nxt;
	logic [RW-1:0] cur;
	logic [RW-1:0] trial;

	always_comb begin
		cur   = {in_sq.rem[RW-3:0], in_sq.n[N_W-1 -: 2]};
		trial = RW'({in_sq.root, 2'b01});
		nxt.n = in_sq.n << 2;
		if (cur >= trial) begin
			nxt.rem  = cur - trial;
			nxt.root = {in_sq.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = cur;
			nxt.root = {in_sq.root[ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_q   <= nxt;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_sq    = sq_q;
	assign out_side  = side_q;

endmodule

>>> rtl/core/aarm_div_cell.sv
module aarm_div_cell import aarm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  div_t     in_div,
	input  dv_side_t in_side,
	output logic     out_valid,
	output div_t     out_div,
	output dv_side_t out_side
);

	logic     valid_q;
	div_t     div_q;
	dv_side_t side_q;
	div_t     nxt;
	dstep_t   sx;
	dstep_t   sy;
	dstep_t   sz;

	always_comb begin
		sx        = div_step(in_div.rem_x, in_div.root);
		sy        = div_step(in_div.rem_y, in_div.root);
		sz        = div_step(in_div.rem_z, in_div.root);
		nxt.root  = in_div.root;
		nxt.rem_x = sx.rem;
		nxt.rem_y = sy.rem;
		nxt.rem_z = sz.rem;
		nxt.q_x   = {in_div.q_x[QB-2:0], sx.b};
		nxt.q_y   = {in_div.q_y[QB-2:0], sy.b};
		nxt.q_z   = {in_div.q_z[QB-2:0], sz.b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_q  <= nxt;
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_div   = div_q;
	assign out_side  = side_q;

endmodule

>>> rtl/core/aarm_matrix.sv
module aarm_matrix import aarm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  div_t     in_div,
	input  dv_side_t in_side,
	output logic     out_valid,
	output mat_t     out_mat
);

	localparam logic [QB-1:0]        ONE_Q = QB'(1) << FRAC_BITS;
	localparam logic signed [TW+1:0] ONE_D = (TW + 2)'(1) << FRAC_BITS;
	localparam logic signed [2*TW-1:0] RHALF = (2 * TW)'(1) << (FRAC_BITS - 1);
	localparam logic signed [PW-1:0] ONE2  = PW'(1) << (2 * FRAC_BITS);
	localparam logic signed [PW-1:0] FHALF = PW'(1) << (FS - 1);
	localparam logic signed [PW-1:0] SAT_P = PW'(16384);
	localparam logic signed [PW-1:0] SAT_N = -SAT_P;

	function automatic logic signed [TW-1:0] mk_u(input logic [QB-1:0] q,
			input logic sgn, input logic zero);
		logic [QB-1:0] qc;
		qc = (q > ONE_Q) ? ONE_Q : q;
		if (zero) begin
			return '0;
		end
		return sgn ? -$signed(TW'(qc)) : $signed(TW'(qc));
	endfunction

	function automatic logic signed [TW+1:0] rnd_f(input logic signed [2*TW-1:0] v);
		logic signed [2*TW-1:0] t;
		t = (v + RHALF) >>> FRAC_BITS;
		return t[TW+1:0];
	endfunction

	function automatic logic signed [15:0] finish(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] t;
		t = (v + FHALF) >>> FS;
		if (t > SAT_P) begin
			t = SAT_P;
		end else if (t < SAT_N) begin
			t = SAT_N;
		end
		return t[15:0];
	endfunction

	logic signed [TW-1:0]   ux;
	logic signed [TW-1:0]   uy;
	logic signed [TW-1:0]   uz;
	logic signed [TW-1:0]   s;
	logic signed [2*TW-1:0] pxx_s1, pyy_s1, pzz_s1, pxy_s1, pxz_s1, pyz_s1;
	logic signed [2*TW-1:0] wsx_s1, wsy_s1, wsz_s1;
	logic signed [TW-1:0]   c_s1;
	logic                   v_s1;
	logic signed [TW+1:0]   omc;
	logic signed [PW-1:0]   ax_s2, ay_s2, az_s2, bxy_s2, bxz_s2, byz_s2;
	logic signed [PW-1:0]   wsx_s2, wsy_s2, wsz_s2;
	logic                   v_s2;
	logic                   valid_q;
	mat_t                   mat_q;

	always_comb begin
		ux  = mk_u(in_div.q_x, in_side.sgn_x, in_side.zero);
		uy  = mk_u(in_div.q_y, in_side.sgn_y, in_side.zero);
		uz  = mk_u(in_div.q_z, in_side.sgn_z, in_side.zero);
		s   = in_side.trig.s;
		omc = ONE_D - (TW + 2)'(c_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s1 <= (2 * TW)'(ux) * (2 * TW)'(ux);
			pyy_s1 <= (2 * TW)'(uy) * (2 * TW)'(uy);
			pzz_s1 <= (2 * TW)'(uz) * (2 * TW)'(uz);
			pxy_s1 <= (2 * TW)'(ux) * (2 * TW)'(uy);
			pxz_s1 <= (2 * TW)'(ux) * (2 * TW)'(uz);
			pyz_s1 <= (2 * TW)'(uy) * (2 * TW)'(uz);
			wsx_s1 <= (2 * TW)'(ux) * (2 * TW)'(s);
			wsy_s1 <= (2 * TW)'(uy) * (2 * TW)'(s);
			wsz_s1 <= (2 * TW)'(uz) * (2 * TW)'(s);
			c_s1   <= in_side.trig.c;

			ax_s2  <= PW'(omc) * PW'(rnd_f(pxx_s1) - ONE_D);
			ay_s2  <= PW'(omc) * PW'(rnd_f(pyy_s1) - ONE_D);
			az_s2  <= PW'(omc) * PW'(rnd_f(pzz_s1) - ONE_D);
			bxy_s2 <= PW'(omc) * PW'(rnd_f(pxy_s1));
			bxz_s2 <= PW'(omc) * PW'(rnd_f(pxz_s1));
			byz_s2 <= PW'(omc) * PW'(rnd_f(pyz_s1));
			wsx_s2 <= PW'(wsx_s1);
			wsy_s2 <= PW'(wsy_s1);
			wsz_s2 <= PW'(wsz_s1);

			mat_q.r00 <= finish(ONE2 + ax_s2);
			mat_q.r11 <= finish(ONE2 + ay_s2);
			mat_q.r22 <= finish(ONE2 + az_s2);
			mat_q.r01 <= finish(wsz_s2 + bxy_s2);
			mat_q.r10 <= finish(bxy_s2 - wsz_s2);
			mat_q.r02 <= finish(bxz_s2 - wsy_s2);
			mat_q.r20 <= finish(wsy_s2 + bxz_s2);
			mat_q.r12 <= finish(wsx_s2 + byz_s2);
			mat_q.r21 <= finish(byz_s2 - wsx_s2);
		end
	end

	assign out_valid = valid_q;
	assign out_mat   = mat_q;

endmodule

>>> rtl/core/axis_angle_rotation_matrix.sv
// Builds the 3x3 rotation matrix (Q1.14, saturated to +-1) for an axis of any
// scale and an angle in Q2.13 radians. The block is a fixed pipeline: three
// input stages, one CORDIC cell per iteration (16), one square-root cell per
// root bit (24), one divider cell per quotient bit (16, three axis lanes per
// cell) and three matrix stages. It takes one item every cycle; the whole
// pipeline holds while a result waits at the output and ready is then low. An
// all-zero axis gives cos times identity.
`include "axis_angle_rotation_matrix_macros.svh"

module axis_angle_rotation_matrix import aarm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	aarm_in_if.sink    in_item,
	aarm_out_if.source out_item
);

	logic en;

	logic               v_s1;
	logic signed [15:0] ax_s1, ay_s1, az_s1, ang_s1;

	logic                 v_s2;
	logic [LEN_W-1:0]     sqx_s2, sqy_s2, sqz_s2;
	axis_t                axis_s2;
	logic signed [ZW-1:0] z_s2;
	logic                 flip_s2;
	logic signed [ZW-1:0] z0;

	logic  v_s3;
	axis_t axis_s3;
	cord_t cord_s3;

	logic     cd_v [0:CSTG];
	cord_t    cd_st [0:CSTG];
	axis_t    cd_ax [0:CSTG];

	logic     sq_v [0:SQ_STEPS];
	sqrt_t    sq_st [0:SQ_STEPS];
	sq_side_t sq_side [0:SQ_STEPS];

	logic     dv_v [0:QB];
	div_t     dv_st [0:QB];
	dv_side_t dv_side [0:QB];

	logic                 m_valid;
	mat_t                 mat;
	logic signed [CW-1:0] xf;
	logic signed [CW-1:0] yf;
	localparam logic signed [CW-1:0] RHALF = (RS > 0) ? (CW'(1) << (RS - 1)) : '0;

	assign en            = !m_valid || out_item.ready;
	assign in_item.ready = en;

	always_comb begin
		z0 = ZW'(ang_s1) <<< ANG_SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_item.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= in_item.axis_x;
			ay_s1  <= in_item.axis_y;
			az_s1  <= in_item.axis_z;
			ang_s1 <= in_item.angle_rad;

			sqx_s2        <= LEN_W'(ax_s1) * LEN_W'(ax_s1);
			sqy_s2        <= LEN_W'(ay_s1) * LEN_W'(ay_s1);
			sqz_s2        <= LEN_W'(az_s1) * LEN_W'(az_s1);
			axis_s2.mag_x <= ax_s1[15] ? 16'(-ax_s1) : 16'(ax_s1);
			axis_s2.mag_y <= ay_s1[15] ? 16'(-ay_s1) : 16'(ay_s1);
			axis_s2.mag_z <= az_s1[15] ? 16'(-az_s1) : 16'(az_s1);
			axis_s2.sgn_x <= ax_s1[15];
			axis_s2.sgn_y <= ay_s1[15];
			axis_s2.sgn_z <= az_s1[15];
			axis_s2.zero  <= 1'b0;
			axis_s2.len2  <= '0;
			if (z0 > HPI_Q30) begin
				z_s2    <= z0 - PI_Q30;
				flip_s2 <= 1'b1;
			end else if (z0 < -HPI_Q30) begin
				z_s2    <= z0 + PI_Q30;
				flip_s2 <= 1'b1;
			end else begin
				z_s2    <= z0;
				flip_s2 <= 1'b0;
			end

			axis_s3.mag_x <= axis_s2.mag_x;
			axis_s3.mag_y <= axis_s2.mag_y;
			axis_s3.mag_z <= axis_s2.mag_z;
			axis_s3.sgn_x <= axis_s2.sgn_x;
			axis_s3.sgn_y <= axis_s2.sgn_y;
			axis_s3.sgn_z <= axis_s2.sgn_z;
			axis_s3.len2  <= sqx_s2 + sqy_s2 + sqz_s2;
			axis_s3.zero  <= (sqx_s2 + sqy_s2 + sqz_s2) == '0;
			cord_s3.x     <= CORD_GAIN;
			cord_s3.y     <= '0;
			cord_s3.z     <= z_s2;
			cord_s3.flip  <= flip_s2;
		end
	end

	assign cd_v[0]  = v_s3;
	assign cd_st[0] = cord_s3;
	assign cd_ax[0] = axis_s3;

	for (genvar g = 0; g < CSTG; g++) begin : g_cordic
		aarm_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.idx       (IW'(g)),
			.in_valid  (cd_v[g]),
			.in_cord   (cd_st[g]),
			.in_axis   (cd_ax[g]),
			.out_valid (cd_v[g+1]),
			.out_cord  (cd_st[g+1]),
			.out_axis  (cd_ax[g+1])
		);
	end

	// sign flip before rounding, as the rounding is not symmetric
	always_comb begin
		xf = cd_st[CSTG].flip ? -cd_st[CSTG].x : cd_st[CSTG].x;
		yf = cd_st[CSTG].flip ? -cd_st[CSTG].y : cd_st[CSTG].y;
	end

	assign sq_v[0]            = cd_v[CSTG];
	assign sq_st[0].rem       = '0;
	assign sq_st[0].root      = '0;
	assign sq_st[0].n         = {cd_ax[CSTG].len2, 16'b0};
	assign sq_side[0].mag_x   = cd_ax[CSTG].mag_x;
	assign sq_side[0].mag_y   = cd_ax[CSTG].mag_y;
	assign sq_side[0].mag_z   = cd_ax[CSTG].mag_z;
	assign sq_side[0].sgn_x   = cd_ax[CSTG].sgn_x;
	assign sq_side[0].sgn_y   = cd_ax[CSTG].sgn_y;
	assign sq_side[0].sgn_z   = cd_ax[CSTG].sgn_z;
	assign sq_side[0].zero    = cd_ax[CSTG].zero;
	assign sq_side[0].trig.c  = TW'((xf + RHALF) >>> RS);
	assign sq_side[0].trig.s  = TW'((yf + RHALF) >>> RS);

	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
		aarm_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (sq_v[g]),
			.in_sq     (sq_st[g]),
			.in_side   (sq_side[g]),
			.out_valid (sq_v[g+1]),
			.out_sq    (sq_st[g+1]),
			.out_side  (sq_side[g+1])
		);
	end

	assign dv_v[0]       = sq_v[SQ_STEPS];
	assign dv_st[0].root = sq_st[SQ_STEPS].root;
	assign dv_st[0].rem_x = (DW'(sq_side[SQ_STEPS].mag_x) << NSH)
		+ DW'(sq_st[SQ_STEPS].root >> 1);
	assign dv_st[0].rem_y = (DW'(sq_side[SQ_STEPS].mag_y) << NSH)
		+ DW'(sq_st[SQ_STEPS].root >> 1);
	assign dv_st[0].rem_z = (DW'(sq_side[SQ_STEPS].mag_z) << NSH)
		+ DW'(sq_st[SQ_STEPS].root >> 1);
	assign dv_st[0].q_x     = '0;
	assign dv_st[0].q_y     = '0;
	assign dv_st[0].q_z     = '0;
	assign dv_side[0].sgn_x = sq_side[SQ_STEPS].sgn_x;
	assign dv_side[0].sgn_y = sq_side[SQ_STEPS].sgn_y;
	assign dv_side[0].sgn_z = sq_side[SQ_STEPS].sgn_z;
	assign dv_side[0].zero  = sq_side[SQ_STEPS].zero;
	assign dv_side[0].trig  = sq_side[SQ_STEPS].trig;

	for (genvar g = 0; g < QB; g++) begin : g_div
		aarm_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (dv_v[g]),
			.in_div    (dv_st[g]),
			.in_side   (dv_side[g]),
			.out_valid (dv_v[g+1]),
			.out_div   (dv_st[g+1]),
			.out_side  (dv_side[g+1])
		);
	end

	aarm_matrix u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv_v[QB]),
		.in_div    (dv_st[QB]),
		.in_side   (dv_side[QB]),
		.out_valid (m_valid),
		.out_mat   (mat)
	);

	assign out_item.valid = m_valid;
	assign out_item.r00   = mat.r00;
	assign out_item.r01   = mat.r01;
	assign out_item.r02   = mat.r02;
	assign out_item.r10   = mat.r10;
	assign out_item.r11   = mat.r11;
	assign out_item.r12   = mat.r12;
	assign out_item.r20   = mat.r20;
	assign out_item.r21   = mat.r21;
	assign out_item.r22   = mat.r22;

	`AARM_ASSERT_IMP(a_stall_blocks_in, clk, arst_n, out_item.valid && !out_item.ready, !in_item.ready)
	`AARM_ASSERT_NXT(a_accept_enters, clk, arst_n, in_item.valid && in_item.ready, v_s1)
	`AARM_ASSERT_IMP(a_root_nonzero, clk, arst_n, sq_v[SQ_STEPS] && !sq_side[SQ_STEPS].zero, sq_st[SQ_STEPS].root != '0)
	`AARM_ASSERT_IMP(a_r00_range, clk, arst_n, out_item.valid, (out_item.r00 <= 16'sd16384) && (out_item.r00 >= -16'sd16384))

endmodule
